FILE: hw/rtl/damd_pkg.sv
// types, constants and segment decode shared by the averaging meter
`timescale 1ns / 1ps

package damd_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 12;
    localparam int SUPPLY_BITS = 12;
    localparam int SHOWN_BITS  = 14;
    localparam int SEG_BITS    = 10;

    localparam logic [SUPPLY_BITS-1:0] SUPPLY_RESET = 12'd3285;

    // shared serial arithmetic widths
    localparam int CALC_W = 26;
    localparam int DEN_W  = 20;
    localparam int REM_W  = 21;
    localparam int MULB_W = 15;
    localparam int BCD_W  = 16;

    // current mode correction and voltage scaling constants
    localparam logic [CALC_W-1:0] CORR_BIAS = 26'd5900000;
    localparam logic [MULB_W-1:0] CORR_LIN  = 15'd28200;
    localparam logic [DEN_W-1:0]  CORR_DIV  = 20'd1000000;
    localparam logic [MULB_W-1:0] VOLT_MUL  = 15'd1066;
    localparam logic [CALC_W-1:0] VOLT_ROUND = 26'd330;
    localparam logic [DEN_W-1:0]  VOLT_DIV  = 20'd660;
    localparam logic [SHOWN_BITS-1:0] SHOWN_MAX = 14'd9999;

    // segment bits
    localparam logic [SEG_BITS-1:0] SEG_G  = 10'h004;
    localparam logic [SEG_BITS-1:0] SEG_F  = 10'h008;
    localparam logic [SEG_BITS-1:0] SEG_A  = 10'h010;
    localparam logic [SEG_BITS-1:0] SEG_B  = 10'h020;
    localparam logic [SEG_BITS-1:0] SEG_E  = 10'h040;
    localparam logic [SEG_BITS-1:0] SEG_D  = 10'h080;
    localparam logic [SEG_BITS-1:0] SEG_C  = 10'h100;
    localparam logic [SEG_BITS-1:0] SEG_DP = 10'h200;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_current;
        logic [SAMPLE_BITS-1:0] sample_voltage;
        logic                   button_level;
    } in_beat_t;

    typedef struct packed {
        logic [SHOWN_BITS-1:0] shown_value;
        logic [SEG_BITS-1:0]   seg_thousands;
        logic [SEG_BITS-1:0]   seg_hundreds;
        logic [SEG_BITS-1:0]   seg_tens;
        logic [SEG_BITS-1:0]   seg_units;
        logic                  current_mode;
    } out_beat_t;

    // finished value from the arithmetic unit
    typedef struct packed {
        logic [SHOWN_BITS-1:0] shown;
        logic [BCD_W-1:0]      digits;
    } calc_res_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CALC
    } top_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_AVG,
        C_SCALE,
        C_CMUL,
        C_CDIV,
        C_VMUL,
        C_VDIV,
        C_BCD,
        C_DONE
    } calc_state_t;

    // seven segment decode of one decimal digit
    function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_BITS-1:0] seg;
        unique case (digit)
            4'd0:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    seg = SEG_B | SEG_C;
            4'd2:    seg = SEG_A | SEG_B | SEG_G | SEG_E | SEG_D;
            4'd3:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    seg = SEG_F | SEG_G | SEG_B | SEG_C;
            4'd5:    seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_D;
            4'd6:    seg = SEG_A | SEG_F | SEG_G | SEG_C | SEG_E | SEG_D;
            4'd7:    seg = SEG_A | SEG_B | SEG_C;
            4'd8:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    seg = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

FILE: hw/rtl/damd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module damd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/damd_calc.sv
// bit serial arithmetic: average, scaling, correction and decimal split
`timescale 1ns / 1ps

module damd_calc #(
    parameter int FILTER_TAPS = 64
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  start,
    input  logic                                                  mode,
    input  logic [damd_pkg::SAMPLE_BITS+$clog2(FILTER_TAPS)-1:0]  sum,
    input  logic [damd_pkg::SUPPLY_BITS-1:0]                      supply,
    input  logic                                                  ack,
    output logic                                                  done,
    output damd_pkg::calc_res_t                                   res
);

    localparam logic [4:0] DIV_LAST = 5'(damd_pkg::CALC_W - 1);
    localparam logic [4:0] MUL_LAST = 5'(damd_pkg::MULB_W - 1);
    localparam logic [4:0] BCD_LAST = 5'(damd_pkg::SHOWN_BITS - 1);

    damd_pkg::calc_state_t state_reg, state_next;
    logic [4:0] cnt_reg;
    logic       last_step;

    logic [damd_pkg::CALC_W-1:0] num_reg;
    logic [damd_pkg::REM_W-1:0]  rem_reg;
    logic [damd_pkg::DEN_W-1:0]  den_reg;
    logic [damd_pkg::CALC_W-1:0] mul_a_reg;
    logic [damd_pkg::MULB_W-1:0] mul_b_reg;
    logic [damd_pkg::CALC_W-1:0] acc_reg;
    logic [10:0]                 v_reg;
    logic [damd_pkg::SHOWN_BITS-1:0] val_reg;
    logic [damd_pkg::SHOWN_BITS-1:0] sh_reg;
    logic [damd_pkg::BCD_W-1:0]      bcd_reg;

    logic [damd_pkg::REM_W-1:0]  div_trial;
    logic                        div_ge;
    logic [damd_pkg::REM_W-1:0]  div_rem_next;
    logic [damd_pkg::CALC_W-1:0] div_num_next;
    logic [damd_pkg::CALC_W-1:0] mul_acc_next;
    logic [11:0]                 mv_next;
    logic [10:0]                 v_next;
    logic [12:0]                 three_v;
    logic [damd_pkg::MULB_W-1:0] lin_b;
    logic [damd_pkg::CALC_W-1:0] cur_t;
    logic [damd_pkg::SHOWN_BITS-1:0] sat_val;
    logic [damd_pkg::CALC_W-1:0] sat_src;
    logic [damd_pkg::BCD_W-1:0]  bcd_adj;
    logic [damd_pkg::BCD_W-1:0]  bcd_next;

    // one restoring division step
    always_comb
    begin
        div_trial    = {rem_reg[damd_pkg::REM_W-2:0], num_reg[damd_pkg::CALC_W-1]};
        div_ge       = (div_trial >= {1'b0, den_reg});
        div_rem_next = div_ge ? (div_trial - {1'b0, den_reg}) : div_trial;
        div_num_next = {num_reg[damd_pkg::CALC_W-2:0], div_ge};
    end

    // one shift and add multiply step
    assign mul_acc_next = acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);

    // scaled millivolts and current correction factor
    always_comb
    begin
        mv_next = mul_acc_next[23:12];
        v_next  = mv_next[11:1];
        three_v = {2'b00, v_next} + {1'b0, v_next, 1'b0};
        lin_b   = damd_pkg::CORR_LIN - {2'b00, three_v};
        cur_t   = {15'd0, v_reg} + {20'd0, div_num_next[5:0]};
    end

    // saturation of the shown value
    always_comb
    begin
        sat_src = (state_reg == damd_pkg::C_CDIV) ? cur_t : div_num_next;
        if (sat_src > {12'd0, damd_pkg::SHOWN_MAX})
        begin
            sat_val = damd_pkg::SHOWN_MAX;
        end
        else
        begin
            sat_val = sat_src[damd_pkg::SHOWN_BITS-1:0];
        end
    end

    // double dabble step
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
        bcd_next = {bcd_adj[damd_pkg::BCD_W-2:0], sh_reg[damd_pkg::SHOWN_BITS-1]};
    end

    // step limit of the current phase
    always_comb
    begin
        priority case (state_reg)
            damd_pkg::C_AVG, damd_pkg::C_CDIV, damd_pkg::C_VDIV:
                last_step = (cnt_reg == DIV_LAST);
            damd_pkg::C_SCALE, damd_pkg::C_CMUL, damd_pkg::C_VMUL:
                last_step = (cnt_reg == MUL_LAST);
            damd_pkg::C_BCD:
                last_step = (cnt_reg == BCD_LAST);
            default:
                last_step = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            damd_pkg::C_IDLE:  if (start) state_next = damd_pkg::C_AVG;
            damd_pkg::C_AVG:   if (last_step) state_next = damd_pkg::C_SCALE;
            damd_pkg::C_SCALE:
                if (last_step) state_next = mode ? damd_pkg::C_CMUL : damd_pkg::C_VMUL;
            damd_pkg::C_CMUL:  if (last_step) state_next = damd_pkg::C_CDIV;
            damd_pkg::C_CDIV:  if (last_step) state_next = damd_pkg::C_BCD;
            damd_pkg::C_VMUL:  if (last_step) state_next = damd_pkg::C_VDIV;
            damd_pkg::C_VDIV:  if (last_step) state_next = damd_pkg::C_BCD;
            damd_pkg::C_BCD:   if (last_step) state_next = damd_pkg::C_DONE;
            damd_pkg::C_DONE:  if (ack) state_next = damd_pkg::C_IDLE;
            default:           state_next = damd_pkg::C_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done       = (state_reg == damd_pkg::C_DONE);
        res.shown  = val_reg;
        res.digits = bcd_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= damd_pkg::C_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == damd_pkg::C_IDLE || last_step)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            damd_pkg::C_IDLE:
            begin
                num_reg <= damd_pkg::CALC_W'(sum);
                rem_reg <= '0;
                den_reg <= damd_pkg::DEN_W'(FILTER_TAPS);
            end
            damd_pkg::C_AVG, damd_pkg::C_CDIV, damd_pkg::C_VDIV:
            begin
                num_reg <= div_num_next;
                rem_reg <= div_rem_next;
                if (last_step && state_reg == damd_pkg::C_AVG)
                begin
                    mul_a_reg <= {14'd0, div_num_next[11:0]};
                    mul_b_reg <= {3'd0, supply};
                    acc_reg   <= '0;
                end
                if (last_step && state_reg != damd_pkg::C_AVG)
                begin
                    val_reg <= sat_val;
                    sh_reg  <= sat_val;
                    bcd_reg <= '0;
                end
            end
            damd_pkg::C_SCALE, damd_pkg::C_CMUL, damd_pkg::C_VMUL:
            begin
                acc_reg   <= mul_acc_next;
                mul_a_reg <= {mul_a_reg[damd_pkg::CALC_W-2:0], 1'b0};
                mul_b_reg <= {1'b0, mul_b_reg[damd_pkg::MULB_W-1:1]};
                if (last_step && state_reg == damd_pkg::C_SCALE)
                begin
                    acc_reg <= '0;
                    v_reg   <= v_next;
                    if (mode)
                    begin
                        mul_a_reg <= {15'd0, v_next};
                        mul_b_reg <= lin_b;
                    end
                    else
                    begin
                        mul_a_reg <= {14'd0, mv_next};
                        mul_b_reg <= damd_pkg::VOLT_MUL;
                    end
                end
                if (last_step && state_reg == damd_pkg::C_CMUL)
                begin
                    num_reg <= mul_acc_next + damd_pkg::CORR_BIAS;
                    rem_reg <= '0;
                    den_reg <= damd_pkg::CORR_DIV;
                end
                if (last_step && state_reg == damd_pkg::C_VMUL)
                begin
                    num_reg <= mul_acc_next + damd_pkg::VOLT_ROUND;
                    rem_reg <= '0;
                    den_reg <= damd_pkg::VOLT_DIV;
                end
            end
            damd_pkg::C_BCD:
            begin
                bcd_reg <= bcd_next;
                sh_reg  <= {sh_reg[damd_pkg::SHOWN_BITS-2:0], 1'b0};
            end
            default:
            begin
                val_reg <= val_reg;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dual_adc_average_meter_display.sv
// top level of the dual channel averaging meter with four digit display
`timescale 1ns / 1ps

// Each input beat carries one current sample, one voltage sample and the
// mode button level. Both samples enter FILTER_TAPS deep boxcar rings; the
// running sum of the channel chosen by the mode is averaged, scaled by
// supply_mv, corrected (current mode) or scaled by 533/330 (voltage mode)
// and split into four segment words. One output beat follows each input.
// From the input beat to out_valid the item passes the ring read, then the
// bit serial unit runs 26 steps of division for the average, 15 multiply
// steps for scaling, 15 more multiply steps and 26 division steps for the
// mode formula, and 14 steps of binary to decimal conversion; then the
// output register is loaded. One item is in flight at a time: no new
// input beat is accepted until the result has moved to the output
// register.
// The result sits in an output register; the next item is accepted while
// it waits. If out_stall holds the output register full, the finished
// value waits in the arithmetic unit and in_stall stays high.
// A falling button edge toggles the mode after the result is issued.
// Reset clears sums, ring position, selects current mode and loads
// supply_mv with 3285; ring contents need no clearing. The user must write
// supply_mv via cfg_we and cfg_data while idle; the block does not check.

module dual_adc_average_meter_display #(
    parameter int FILTER_TAPS = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  damd_pkg::in_beat_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output damd_pkg::out_beat_t          out_data,
    input  logic                         cfg_we,
    input  logic [damd_pkg::SUPPLY_BITS-1:0] cfg_data
);

    localparam int PW    = $clog2(FILTER_TAPS);
    localparam int SUM_W = damd_pkg::SAMPLE_BITS + PW;
    localparam logic [PW-1:0] POS_LAST = PW'(FILTER_TAPS - 1);

    damd_pkg::top_state_t state_reg, state_next;

    logic [damd_pkg::SUPPLY_BITS-1:0] supply_reg;
    logic [SUM_W-1:0] sum_cur_reg, sum_vol_reg;
    logic [SUM_W-1:0] sum_cur_next, sum_vol_next;
    logic [PW-1:0]    pos_reg;
    logic             full_reg;
    logic             mode_reg;
    logic             last_btn_reg;
    logic [damd_pkg::SAMPLE_BITS-1:0] s_cur_reg, s_vol_reg;
    logic             btn_reg;
    logic             out_valid_reg;
    damd_pkg::out_beat_t out_data_reg;

    logic accept;
    logic calc_start;
    logic calc_done;
    logic load_out;
    damd_pkg::calc_res_t calc_res;
    logic [damd_pkg::SAMPLE_BITS-1:0] old_cur, old_vol;
    logic [SUM_W-1:0] calc_sum;

    // handshake
    assign accept     = in_valid && (state_reg == damd_pkg::T_IDLE);
    assign in_stall   = (state_reg != damd_pkg::T_IDLE);
    assign calc_start = (state_reg == damd_pkg::T_READ);
    assign load_out   = (state_reg == damd_pkg::T_CALC) && calc_done &&
                        (!out_valid_reg || !out_stall);

    // sample rings
    damd_ram #(.WIDTH(damd_pkg::SAMPLE_BITS), .DEPTH(FILTER_TAPS)) u_ring_cur (
        .clk   (clk),
        .we    (calc_start),
        .waddr (pos_reg),
        .wdata (s_cur_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (old_cur)
    );

    damd_ram #(.WIDTH(damd_pkg::SAMPLE_BITS), .DEPTH(FILTER_TAPS)) u_ring_vol (
        .clk   (clk),
        .we    (calc_start),
        .waddr (pos_reg),
        .wdata (s_vol_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (old_vol)
    );

    // running sums, oldest sample leaves once the ring has wrapped
    always_comb
    begin
        sum_cur_next = sum_cur_reg + SUM_W'(s_cur_reg)
                       - (full_reg ? SUM_W'(old_cur) : '0);
        sum_vol_next = sum_vol_reg + SUM_W'(s_vol_reg)
                       - (full_reg ? SUM_W'(old_vol) : '0);
        calc_sum     = mode_reg ? sum_cur_next : sum_vol_next;
    end

    damd_calc #(.FILTER_TAPS(FILTER_TAPS)) u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (calc_start),
        .mode   (mode_reg),
        .sum    (calc_sum),
        .supply (supply_reg),
        .ack    (load_out),
        .done   (calc_done),
        .res    (calc_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            damd_pkg::T_IDLE: if (accept) state_next = damd_pkg::T_READ;
            damd_pkg::T_READ: state_next = damd_pkg::T_CALC;
            damd_pkg::T_CALC: if (load_out) state_next = damd_pkg::T_IDLE;
            default:          state_next = damd_pkg::T_IDLE;
        endcase
    end

    // output beat
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= damd_pkg::T_IDLE;
            supply_reg    <= damd_pkg::SUPPLY_RESET;
            sum_cur_reg   <= '0;
            sum_vol_reg   <= '0;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            mode_reg      <= 1'b1;
            last_btn_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                supply_reg <= cfg_data;
            end
            if (calc_start)
            begin
                sum_cur_reg <= sum_cur_next;
                sum_vol_reg <= sum_vol_next;
                if (pos_reg == POS_LAST)
                begin
                    pos_reg  <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + PW'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (!btn_reg && last_btn_reg)
                begin
                    mode_reg <= !mode_reg;
                end
                last_btn_reg <= btn_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_cur_reg <= in_data.sample_current;
            s_vol_reg <= in_data.sample_voltage;
            btn_reg   <= in_data.button_level;
        end
        if (load_out)
        begin
            out_data_reg.shown_value   <= calc_res.shown;
            out_data_reg.seg_thousands <= damd_pkg::seg_of(calc_res.digits[15:12]) |
                                          (mode_reg ? damd_pkg::SEG_DP : '0);
            out_data_reg.seg_hundreds  <= damd_pkg::seg_of(calc_res.digits[11:8]) |
                                          (mode_reg ? '0 : damd_pkg::SEG_DP);
            out_data_reg.seg_tens      <= damd_pkg::seg_of(calc_res.digits[7:4]);
            out_data_reg.seg_units     <= damd_pkg::seg_of(calc_res.digits[3:0]);
            out_data_reg.current_mode  <= mode_reg;
        end
    end

endmodule
